// ===== sv/pklpt_pkg.sv =====
// Shared types and constants for the pair-key linear probe table.
`default_nettype none
package pklpt_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int STAMP_W = 8;
	localparam int OP_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_DEFINE   = 3'd0,
		OP_SET      = 3'd1,
		OP_GET      = 3'd2,
		OP_ROLLBACK = 3'd3,
		OP_COMMIT   = 3'd4
	} op_t;

	// Slot write flavors
	typedef enum logic [2:0] {
		WR_NONE,
		WR_ZERO,
		WR_INSERT,
		WR_VALUE_STAMP,
		WR_VALUE,
		WR_CLEAR_KEYS,
		WR_STAMP
	} wr_mode_t;

	typedef struct packed {
		logic     load;
		logic     hash_step;
		logic     bound_calc;
		logic     idx_home;
		logic     idx_zero;
		logic     idx_next;
		logic     rd;
		wr_mode_t wr_mode;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     res_load;
		logic     res_ok;
		logic     res_full;
		logic     res_val;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic key_zero;
		logic hash_done;
		logic at_last;
		logic idx_end;
		logic used;
		logic match;
		logic val_zero;
		logic over_fill;
		logic sweep_hit;
		logic cnt_nz;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/pair_key_linear_probe_table_top.sv =====
// Top level of the pair-key linear probe table.
// Usage:
//   Input channel (in_valid/in_stall) takes one word: operation, key pair, value
//   and stamp. Output channel (out_valid/out_stall) returns one word per input:
//   success, value_out, fill_exceeded.
//   Define, set and get reduce the key hash to a home slot with a reciprocal
//   multiply and one correction (two steps), then probe the slot RAM slot by
//   slot (read, then evaluate and write).
//   Rollback and commit sweep every slot.
//   Define, set and get with a zero key, and unknown operations, answer all
//   zero from the decode state once the output register is free.
//   One item is in flight at a time; in_stall is high while it is worked on.
//   A result sits in an output register; the next item is accepted while it
//   waits, and that item's result holds back until the word is taken.
//   After reset the slot RAM is zeroed one slot per cycle while in_stall
//   stays high.
`default_nettype none
module pair_key_linear_probe_table_top #(
	parameter int TABLE_SIZE = pklpt_pkg::TABLE_SIZE_DEF,
	parameter int WORD_WIDTH = pklpt_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [pklpt_pkg::OP_W-1:0]    operation,
	input  wire logic [WORD_WIDTH-1:0]         first_key,
	input  wire logic [WORD_WIDTH-1:0]         second_key,
	input  wire logic [WORD_WIDTH-1:0]         value_in,
	input  wire logic [pklpt_pkg::STAMP_W-1:0] stamp_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               success,
	output logic      [WORD_WIDTH-1:0]         value_out,
	output logic                               fill_exceeded
);

	pklpt_pkg::cmd_t    cmd;
	pklpt_pkg::status_t status;

	pklpt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.status  (status)
	);

	pklpt_datapath #(
		.TABLE_SIZE(TABLE_SIZE),
		.WORD_WIDTH(WORD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (operation),
		.first_key    (first_key),
		.second_key   (second_key),
		.value_in     (value_in),
		.stamp_in     (stamp_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.success      (success),
		.value_out    (value_out),
		.fill_exceeded(fill_exceeded)
	);

endmodule
`default_nettype wire

// ===== sv/pklpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pklpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/pklpt_datapath.sv =====
// Datapath: slot RAM, hash reduction, probe index, entry count and result word.
`default_nettype none
module pklpt_datapath #(
	parameter int TABLE_SIZE = pklpt_pkg::TABLE_SIZE_DEF,
	parameter int WORD_WIDTH = pklpt_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pklpt_pkg::cmd_t               cmd,
	output pklpt_pkg::status_t                 status,
	input  wire logic [pklpt_pkg::OP_W-1:0]    operation,
	input  wire logic [WORD_WIDTH-1:0]         first_key,
	input  wire logic [WORD_WIDTH-1:0]         second_key,
	input  wire logic [WORD_WIDTH-1:0]         value_in,
	input  wire logic [pklpt_pkg::STAMP_W-1:0] stamp_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               success,
	output logic      [WORD_WIDTH-1:0]         value_out,
	output logic                               fill_exceeded
);

	localparam int SW = pklpt_pkg::STAMP_W;
	localparam int ADDR_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam int HASH_STEPS = 2;
	localparam int HC_W = $clog2(HASH_STEPS + 1);
	localparam int E_W = 3 * WORD_WIDTH + SW;
	localparam int FILL_LIMIT = (TABLE_SIZE >> 1) + (TABLE_SIZE >> 2);
	// Reciprocal for the home-slot reduction: floor(2^WORD_WIDTH / TABLE_SIZE)
	localparam int QUOT_W = WORD_WIDTH - ADDR_W + 1;
	localparam int PROD_W = WORD_WIDTH + QUOT_W;
	localparam int QN_W = (QUOT_W > ADDR_W + 1) ? QUOT_W : ADDR_W + 1;
	localparam logic [WORD_WIDTH:0] POW2W = {1'b1, {WORD_WIDTH{1'b0}}};
	localparam logic [QUOT_W-1:0] RECIP = QUOT_W'(POW2W / (WORD_WIDTH+1)'(TABLE_SIZE));

	// Captured item
	logic [pklpt_pkg::OP_W-1:0] op_q;
	logic [WORD_WIDTH-1:0]      a_q, b_q, v_q, h_q;
	logic [SW-1:0]              s_q;
	logic [HC_W-1:0]            hcnt_q;
	logic [ADDR_W:0]            rem_q;
	logic [QUOT_W-1:0]          quot_q;
	logic [ADDR_W-1:0]          idx_q, last_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       out_valid_q, success_q, full_q, val_sel_q;
	logic [WORD_WIDTH-1:0]      val_q;

	logic [E_W-1:0]        rdata, wdata;
	logic [WORD_WIDTH-1:0] r_first, r_second, r_value;
	logic [SW-1:0]         r_stamp;
	logic [WORD_WIDTH-1:0] hash_full;
	logic [PROD_W-1:0]     prod;
	logic [QUOT_W-1:0]     quot;
	logic [QN_W-1:0]       qn_full;
	logic [ADDR_W:0]       qn, rdiff, rfix;
	logic [ADDR_W+1:0]     bnd_t, bnd_u, bnd_v;
	logic                  we;

	assign r_first  = rdata[E_W-1 -: WORD_WIDTH];
	assign r_second = rdata[2*WORD_WIDTH+SW-1 -: WORD_WIDTH];
	assign r_value  = rdata[WORD_WIDTH+SW-1 -: WORD_WIDTH];
	assign r_stamp  = rdata[SW-1:0];

	// Wrapping home hash before the table-size reduction
	assign hash_full = (first_key << 2) + ((second_key << 5) ^ (second_key >> 17));

	// Step one: quotient estimate, at most one below the true quotient
	assign prod = PROD_W'(h_q) * PROD_W'(RECIP);
	assign quot = prod[WORD_WIDTH +: QUOT_W];

	// Step two: remainder below twice the table size, then one correction
	always_comb begin
		qn_full = QN_W'(quot_q) * QN_W'(TABLE_SIZE);
		qn      = qn_full[ADDR_W:0];
		rdiff   = (ADDR_W+1)'(h_q) - qn;
		rfix    = (rdiff >= (ADDR_W+1)'(TABLE_SIZE)) ? rdiff - (ADDR_W+1)'(TABLE_SIZE) : rdiff;
	end

	// Bound slot: home + count - 1, wrapped into the table
	always_comb begin
		bnd_t = (ADDR_W+2)'(rem_q) + (ADDR_W+2)'(cnt_q) + (ADDR_W+2)'(TABLE_SIZE - 1);
		bnd_u = (bnd_t >= (ADDR_W+2)'(2 * TABLE_SIZE)) ?
			bnd_t - (ADDR_W+2)'(2 * TABLE_SIZE) : bnd_t;
		bnd_v = (bnd_u >= (ADDR_W+2)'(TABLE_SIZE)) ? bnd_u - (ADDR_W+2)'(TABLE_SIZE) : bnd_u;
	end

	// Item capture, hashing, probe index and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hcnt_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.load) begin
				hcnt_q <= '0;
			end else if (cmd.hash_step) begin
				hcnt_q <= hcnt_q + HC_W'(1);
			end
			if (cmd.idx_zero) begin
				idx_q <= '0;
			end else if (cmd.idx_home) begin
				idx_q <= rem_q[ADDR_W-1:0];
			end else if (cmd.idx_next) begin
				idx_q <= (idx_q == ADDR_W'(TABLE_SIZE - 1)) ? '0 : idx_q + ADDR_W'(1);
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			a_q   <= first_key;
			b_q   <= second_key;
			v_q   <= value_in;
			s_q   <= stamp_in;
			h_q   <= hash_full;
			rem_q <= '0;
		end else if (cmd.hash_step) begin
			if (hcnt_q == '0) begin
				quot_q <= quot;
			end else begin
				rem_q <= rfix;
			end
		end
		if (cmd.bound_calc) begin
			last_q <= bnd_v[ADDR_W-1:0];
		end
	end

	// Slot write data
	always_comb begin
		we = 1'b1;
		case (cmd.wr_mode)
			pklpt_pkg::WR_ZERO:        wdata = '0;
			pklpt_pkg::WR_INSERT:      wdata = {a_q, b_q, v_q, s_q};
			pklpt_pkg::WR_VALUE_STAMP: wdata = {r_first, r_second, v_q, s_q};
			pklpt_pkg::WR_VALUE:       wdata = {r_first, r_second, v_q, r_stamp};
			pklpt_pkg::WR_CLEAR_KEYS:  wdata = {{(3*WORD_WIDTH){1'b0}}, r_stamp};
			pklpt_pkg::WR_STAMP:       wdata = {r_first, r_second, r_value, s_q};
			default: begin
				we    = 1'b0;
				wdata = rdata;
			end
		endcase
	end

	pklpt_ram #(
		.WIDTH(E_W),
		.DEPTH(TABLE_SIZE)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(idx_q),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(idx_q),
		.rdata(rdata)
	);

	// Result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			success_q <= cmd.res_ok;
			full_q    <= cmd.res_full;
			val_sel_q <= cmd.res_val;
			val_q     <= r_value;
		end
	end

	assign out_valid     = out_valid_q;
	assign success       = success_q;
	assign fill_exceeded = full_q;
	assign value_out     = val_sel_q ? val_q : '0;

	// Status back to the controller
	always_comb begin
		status.op        = op_q;
		status.key_zero  = (a_q == '0) || (b_q == '0);
		status.hash_done = (hcnt_q == HC_W'(HASH_STEPS));
		status.at_last   = (idx_q == last_q);
		status.idx_end   = (idx_q == ADDR_W'(TABLE_SIZE - 1));
		status.used      = (r_first != '0) && (r_second != '0);
		status.match     = (r_first == a_q) && (r_second == b_q);
		status.val_zero  = (r_value == '0);
		status.over_fill = (cnt_q > CNT_W'(FILL_LIMIT + 1));
		status.sweep_hit = (r_stamp > s_q) && (r_first != '0);
		status.cnt_nz    = (cnt_q != '0);
		status.out_busy  = out_valid_q && out_stall;
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_SIZE)) else $error("entry count above table size");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= ADDR_W'(TABLE_SIZE - 1)) else $error("probe index out of table");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hash_step |=> rem_q < (ADDR_W+1)'(TABLE_SIZE)) else $error("hash remainder too big");
	a_last_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bound_calc |=> last_q <= ADDR_W'(TABLE_SIZE - 1)) else $error("bound slot out of table");
`endif

endmodule
`default_nettype wire

// ===== sv/pklpt_ctrl.sv =====
// Controller: sequences clearing, hashing, probing and table sweeps.
`default_nettype none
module pklpt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output pklpt_pkg::cmd_t          cmd,
	input  wire pklpt_pkg::status_t  status
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_HASH,
		S_BOUND,
		S_PROBE_RD,
		S_PROBE_EV,
		S_SWEEP_RD,
		S_SWEEP_EV,
		S_SWEEP_DONE
	} state_t;

	state_t state_q, state_d;
	logic   first_q, first_d;
	logic   is_define, is_set, is_get, is_sweep, stop;

	assign is_define = (status.op == pklpt_pkg::OP_DEFINE);
	assign is_set    = (status.op == pklpt_pkg::OP_SET);
	assign is_get    = (status.op == pklpt_pkg::OP_GET);
	assign is_sweep  = (status.op == pklpt_pkg::OP_ROLLBACK) ||
		(status.op == pklpt_pkg::OP_COMMIT);
	assign stop      = status.at_last || !status.used || status.match;
	assign in_stall  = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		first_d = first_q;
		cmd     = '0;
		cmd.wr_mode = pklpt_pkg::WR_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_mode = pklpt_pkg::WR_ZERO;
				if (status.idx_end) begin
					cmd.idx_zero = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.idx_next = 1'b1;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if ((is_define || is_set || is_get) && !status.key_zero) begin
					state_d = S_HASH;
				end else if (is_sweep) begin
					cmd.idx_zero = 1'b1;
					state_d = S_SWEEP_RD;
				end else if (!status.out_busy) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_HASH: begin
				if (status.hash_done) begin
					state_d = S_BOUND;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			S_BOUND: begin
				cmd.bound_calc = 1'b1;
				cmd.idx_home = 1'b1;
				first_d = 1'b1;
				state_d = S_PROBE_RD;
			end
			S_PROBE_RD: begin
				cmd.rd = 1'b1;
				state_d = S_PROBE_EV;
			end
			S_PROBE_EV: begin
				if (is_get) begin
					if (status.match || (!first_q && (status.at_last || !status.used))) begin
						if (!status.out_busy) begin
							cmd.res_load = 1'b1;
							cmd.res_ok = status.match && !status.val_zero;
							cmd.res_val = status.match;
							state_d = S_IDLE;
						end
					end else begin
						cmd.idx_next = 1'b1;
						first_d = 1'b0;
						state_d = S_PROBE_RD;
					end
				end else if (!stop) begin
					cmd.idx_next = 1'b1;
					state_d = S_PROBE_RD;
				end else if (!status.out_busy) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
					if (is_define) begin
						if (!status.used) begin
							if (status.over_fill) begin
								cmd.res_full = 1'b1;
							end else begin
								cmd.wr_mode = pklpt_pkg::WR_INSERT;
								cmd.cnt_inc = 1'b1;
								cmd.res_ok = 1'b1;
							end
						end else if (status.match && status.val_zero) begin
							cmd.wr_mode = pklpt_pkg::WR_VALUE_STAMP;
							cmd.res_ok = 1'b1;
						end
					end else if (status.match) begin
						cmd.wr_mode = pklpt_pkg::WR_VALUE;
						cmd.res_ok = 1'b1;
					end
				end
			end
			S_SWEEP_RD: begin
				cmd.rd = 1'b1;
				state_d = S_SWEEP_EV;
			end
			S_SWEEP_EV: begin
				if (status.sweep_hit) begin
					if (status.op == pklpt_pkg::OP_ROLLBACK) begin
						cmd.wr_mode = pklpt_pkg::WR_CLEAR_KEYS;
						cmd.cnt_dec = status.cnt_nz;
					end else begin
						cmd.wr_mode = pklpt_pkg::WR_STAMP;
					end
				end
				if (status.idx_end) begin
					state_d = S_SWEEP_DONE;
				end else begin
					cmd.idx_next = 1'b1;
					state_d = S_SWEEP_RD;
				end
			end
			S_SWEEP_DONE: begin
				if (!status.out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_ok = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
		end
	end

`ifndef SYNTHESIS
	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> cmd.wr_mode == pklpt_pkg::WR_NONE)
		else $error("slot write while idle");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !status.out_busy) else $error("result loaded over a waiting word");
	a_one_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.idx_zero, cmd.idx_home, cmd.idx_next}))
		else $error("conflicting index commands");
`endif

endmodule
`default_nettype wire
